// ===== rtl/buddy_page_allocator_defines.svh =====
// Assertion macros used by the sequencer of the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BPA_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bpa: same-cycle property violated");

// Next-cycle implication, checked out of reset.
`define BPA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bpa: next-cycle property violated");

`endif

// ===== rtl/bpa_pkg.sv =====
// Shared types, codes and helpers of the buddy page allocator.
package bpa_pkg;

   localparam int POOL_PAGES_DEF  = 4096;
   localparam int ORDER_COUNT_DEF = 11;

   localparam int OP_W       = 2;
   localparam int CNT_W      = 12;
   localparam int PAGE_W     = 12;
   localparam int ORD_OUT_W  = 4;
   localparam int STAT_W     = 2;
   localparam int POOL_REG_W = 13;
   localparam int RES_REG_W  = 12;

   localparam logic [POOL_REG_W-1:0] POOL_REG_RESET = 13'd4096;
   localparam logic [RES_REG_W-1:0]  RES_REG_RESET  = 12'd0;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_CNT  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_PAGE = 2'd3;

   // Register indexes
   localparam logic CSR_POOL     = 1'b0;
   localparam logic CSR_RESERVED = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_CARVE,
      S_PUSH_HEAD,
      S_PUSH_LINK,
      S_ALLOC_READ,
      S_ALLOC_UNLINK,
      S_SPLIT,
      S_FREE_READ,
      S_FREE_CHECK,
      S_MERGE_READ,
      S_MERGE_TEST,
      S_RESP
   } state_type;

   typedef struct packed {
      logic tag_we;
      logic next_we;
      logic prev_we;
   } mem_we_type;

   typedef struct packed {
      logic [STAT_W-1:0]    status;
      logic [ORD_OUT_W-1:0] order;
      logic [PAGE_W-1:0]    page;
   } rsp_type;

   // Index of the highest set bit, zero for zero.
   function automatic logic [4:0] high_bit(input logic [31:0] v);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            r = 5'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: register port, result register, sequencer and memories.
//
// Requests arrive on the req_ stream: operation, count and page_index packed in req_tdata.
// One result per request leaves on the rsp_ stream (page, order, status in rsp_tdata).
// Registers pool_pages (index 0) and reserved_pages (index 1) are written on the csr_ port,
// which is always ready; write them only while the block is idle, then issue an init.
// Requests are handled one at a time. Allocate reads the head block, unlinks it and pushes
// one buddy per split; free checks the tag, then reads and folds one buddy per merge step
// before the final list insert. The steps share one read address on the tag and link memories.
// Init sweeps all POOL_PAGES tags (one per cycle), then carves and pushes each block in turn.
// After reset the same tag sweep runs, req_tready staying low.
// The result is held in an output register: a new request is taken while it waits;
// a stalled receiver only holds the next result back, it never drops or repeats one.
module buddy_page_allocator #(
   parameter int POOL_PAGES  = bpa_pkg::POOL_PAGES_DEF,
   parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // operation[1:0], count[13:2], page_index[25:14]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // page_index_out[11:0], granted_order[15:12], status[17:16]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);
   localparam int PW = $clog2(POOL_PAGES);
   localparam int LW = PW + 1;
   localparam int TW = $clog2(ORDER_COUNT) + 1;

   logic [bpa_pkg::POOL_REG_W-1:0] pool_ff, pool_in;
   logic [bpa_pkg::RES_REG_W-1:0]  resv_ff, resv_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   bpa_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                slot_free, res_valid;
   bpa_pkg::rsp_type    res_data;
   logic [PW-1:0]       rd_addr, tag_wa, next_wa, prev_wa;
   logic [TW-1:0]       tag_wd, tag_rd;
   logic [LW-1:0]       next_wd, prev_wd, next_rd, prev_rd;
   bpa_pkg::mem_we_type we;

   // Register writes
   assign csr_ready = 1'b1;
   always_comb begin
      pool_in = pool_ff;
      resv_in = resv_ff;
      if (csr_valid) begin
         case (csr_index)
            bpa_pkg::CSR_POOL:     pool_in = csr_wdata;
            bpa_pkg::CSR_RESERVED: resv_in = csr_wdata[bpa_pkg::RES_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Result register: load on a new result, drop on a transfer
   assign slot_free = !rsp_valid_ff || rsp_tready;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= bpa_pkg::POOL_REG_RESET;
         resv_ff      <= bpa_pkg::RES_REG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_ff      <= pool_in;
         resv_ff      <= resv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   bpa_ctrl #(
      .POOL_PAGES  (POOL_PAGES),
      .ORDER_COUNT (ORDER_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tdata[1:0]),
      .req_count (req_tdata[13:2]),
      .req_page  (req_tdata[25:14]),
      .pool_cfg  (pool_ff),
      .res_cfg   (resv_ff),
      .slot_free (slot_free),
      .res_valid (res_valid),
      .res_data  (res_data),
      .rd_addr   (rd_addr),
      .we        (we),
      .tag_wa    (tag_wa),
      .tag_wd    (tag_wd),
      .next_wa   (next_wa),
      .next_wd   (next_wd),
      .prev_wa   (prev_wa),
      .prev_wd   (prev_wd),
      .tag_rd    (tag_rd),
      .next_rd   (next_rd),
      .prev_rd   (prev_rd)
   );

   bpa_mem #(
      .POOL_PAGES  (POOL_PAGES),
      .ORDER_COUNT (ORDER_COUNT)
   ) u_mem (
      .clock   (clock),
      .rd_addr (rd_addr),
      .we      (we),
      .tag_wa  (tag_wa),
      .tag_wd  (tag_wd),
      .next_wa (next_wa),
      .next_wd (next_wd),
      .prev_wa (prev_wa),
      .prev_wd (prev_wd),
      .tag_rd  (tag_rd),
      .next_rd (next_rd),
      .prev_rd (prev_rd)
   );

endmodule

// ===== rtl/bpa_mem.sv =====
// Tag and link memories of the buddy page allocator, one write and one read port each.
module bpa_mem #(
   parameter int POOL_PAGES  = bpa_pkg::POOL_PAGES_DEF,
   parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF
) (
   input  logic                              clock,
   input  logic [$clog2(POOL_PAGES)-1:0]     rd_addr,
   input  bpa_pkg::mem_we_type               we,
   input  logic [$clog2(POOL_PAGES)-1:0]     tag_wa,
   input  logic [$clog2(ORDER_COUNT):0]      tag_wd,
   input  logic [$clog2(POOL_PAGES)-1:0]     next_wa,
   input  logic [$clog2(POOL_PAGES):0]       next_wd,
   input  logic [$clog2(POOL_PAGES)-1:0]     prev_wa,
   input  logic [$clog2(POOL_PAGES):0]       prev_wd,
   output logic [$clog2(ORDER_COUNT):0]      tag_rd,
   output logic [$clog2(POOL_PAGES):0]       next_rd,
   output logic [$clog2(POOL_PAGES):0]       prev_rd
);
   localparam int PW = $clog2(POOL_PAGES);
   localparam int LW = PW + 1;
   localparam int TW = $clog2(ORDER_COUNT) + 1;

   logic [TW-1:0] tag_mem  [POOL_PAGES];
   logic [LW-1:0] next_mem [POOL_PAGES];
   logic [LW-1:0] prev_mem [POOL_PAGES];

   // Write ports
   always_ff @(posedge clock) begin
      if (we.tag_we) begin
         tag_mem[tag_wa] <= tag_wd;
      end
      if (we.next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (we.prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
   end

   // Registered read port, shared address
   always_ff @(posedge clock) begin
      tag_rd  <= tag_mem[rd_addr];
      next_rd <= next_mem[rd_addr];
      prev_rd <= prev_mem[rd_addr];
   end

endmodule

// ===== rtl/bpa_ctrl.sv =====
// Sequencer of the buddy page allocator: free list heads, split, merge and carve steps.
`include "buddy_page_allocator_defines.svh"
module bpa_ctrl #(
   parameter int POOL_PAGES  = bpa_pkg::POOL_PAGES_DEF,
   parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bpa_pkg::OP_W-1:0]             req_op,
   input  logic [bpa_pkg::CNT_W-1:0]            req_count,
   input  logic [bpa_pkg::PAGE_W-1:0]           req_page,
   input  logic [bpa_pkg::POOL_REG_W-1:0]       pool_cfg,
   input  logic [bpa_pkg::RES_REG_W-1:0]        res_cfg,
   input  logic                                 slot_free,
   output logic                                 res_valid,
   output bpa_pkg::rsp_type                     res_data,
   output logic [$clog2(POOL_PAGES)-1:0]        rd_addr,
   output bpa_pkg::mem_we_type                  we,
   output logic [$clog2(POOL_PAGES)-1:0]        tag_wa,
   output logic [$clog2(ORDER_COUNT):0]         tag_wd,
   output logic [$clog2(POOL_PAGES)-1:0]        next_wa,
   output logic [$clog2(POOL_PAGES):0]          next_wd,
   output logic [$clog2(POOL_PAGES)-1:0]        prev_wa,
   output logic [$clog2(POOL_PAGES):0]          prev_wd,
   input  logic [$clog2(ORDER_COUNT):0]         tag_rd,
   input  logic [$clog2(POOL_PAGES):0]          next_rd,
   input  logic [$clog2(POOL_PAGES):0]          prev_rd
);
   localparam int PW = $clog2(POOL_PAGES);
   localparam int LW = PW + 1;
   localparam int OW = $clog2(ORDER_COUNT);
   localparam int AW = (PW > 15 ? PW : 15) + 2;
   localparam int MAX_COUNT = 1 << (ORDER_COUNT - 1);
   localparam logic [LW-1:0] NIL = LW'(POOL_PAGES);
   localparam logic [OW-1:0] MAXO = OW'(ORDER_COUNT - 1);
   localparam logic [PW-1:0] LAST_PAGE = PW'(POOL_PAGES - 1);
   localparam int OP_W_L = bpa_pkg::OP_W;

   bpa_pkg::state_type state_ff, state_in;
   logic [OP_W_L-1:0] op_ff, op_in;
   logic [OW-1:0] ord_ff, ord_in;
   logic [OW-1:0] i_ff, i_in;
   logic [PW-1:0] cur_ff, cur_in;
   logic [PW-1:0] buddy_ff, buddy_in;
   logic [OW-1:0] push_ord_ff, push_ord_in;
   logic [PW-1:0] push_page_ff, push_page_in;
   logic [LW-1:0] old_head_ff, old_head_in;
   logic [AW-1:0] carve_page_ff, carve_page_in;
   logic [AW-1:0] left_ff, left_in;
   logic [PW-1:0] clear_addr_ff, clear_addr_in;
   logic          boot_ff, boot_in;
   logic [LW-1:0] head_ff [ORDER_COUNT];
   logic [LW-1:0] head_in [ORDER_COUNT];
   logic [bpa_pkg::STAT_W-1:0]    rst_ff, rst_in;
   logic [bpa_pkg::ORD_OUT_W-1:0] rord_ff, rord_in;
   logic [bpa_pkg::PAGE_W-1:0]    rpg_ff, rpg_in;

   // Request decode
   logic [AW-1:0] pool_eff, res_ext, page_ext, req_sz;
   logic [4:0]    cnt_log, rord5, carve_lg;
   logic          cnt_pow2, count_bad, free_bad, found;
   logic [OW-1:0] req_ord, found_ord, carve_ord;
   // Merge step
   logic [AW-1:0] cur_ext, off, msz, buddy_a;
   logic          merge_ok, buddy_free, tag_match, head_valid, old_valid;
   logic          after_init, after_alloc;

   always_comb begin
      pool_eff  = (32'(pool_cfg) > POOL_PAGES) ? AW'(POOL_PAGES) : AW'(pool_cfg);
      res_ext   = AW'(res_cfg);
      page_ext  = AW'(req_page);
      cnt_log   = bpa_pkg::high_bit(32'(req_count));
      cnt_pow2  = (req_count & (req_count - 1'b1)) == '0;
      rord5     = cnt_log + {4'd0, !cnt_pow2};
      req_ord   = OW'(rord5);
      count_bad = (req_count == '0) || (32'(req_count) > MAX_COUNT);
      req_sz    = AW'(1) << req_ord;
      free_bad  = (page_ext < res_ext) || (page_ext + req_sz > pool_eff)
                  || (((page_ext - res_ext) & (req_sz - 1'b1)) != '0);
      found     = 1'b0;
      found_ord = '0;
      for (int k = ORDER_COUNT - 1; k >= 0; k--) begin
         if ((OW'(k) >= req_ord) && (head_ff[k] < NIL)) begin
            found     = 1'b1;
            found_ord = OW'(k);
         end
      end
      carve_lg  = bpa_pkg::high_bit(32'(left_ff));
      carve_ord = (32'(carve_lg) > ORDER_COUNT - 1) ? MAXO : OW'(carve_lg);
      cur_ext   = AW'(cur_ff);
      off       = cur_ext - res_ext;
      msz       = AW'(1) << i_ff;
      buddy_a   = ((off & msz) != '0) ? cur_ext - msz : cur_ext + msz;
      merge_ok  = ((32'(i_ff) + 1) < ORDER_COUNT) && (buddy_a + msz <= pool_eff);
      buddy_free = tag_rd == {1'b1, i_ff};
      tag_match  = tag_rd == {1'b0, ord_ff};
      head_valid = next_rd < NIL;
      old_valid  = old_head_ff < NIL;
      after_init  = op_ff == bpa_pkg::OP_INIT;
      after_alloc = op_ff == bpa_pkg::OP_ALLOC;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpa_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  bpa_pkg::OP_ALLOC: begin
                     state_in = (!count_bad && found) ? bpa_pkg::S_ALLOC_READ
                                                      : bpa_pkg::S_RESP;
                  end
                  bpa_pkg::OP_FREE: begin
                     state_in = (!count_bad && !free_bad) ? bpa_pkg::S_FREE_READ
                                                          : bpa_pkg::S_RESP;
                  end
                  bpa_pkg::OP_INIT: state_in = bpa_pkg::S_CLEAR;
                  default:          state_in = bpa_pkg::S_RESP;
               endcase
            end
         end
         bpa_pkg::S_CLEAR: begin
            if (clear_addr_ff == LAST_PAGE) begin
               if (boot_ff) begin
                  state_in = bpa_pkg::S_IDLE;
               end else if (res_ext >= pool_eff) begin
                  state_in = bpa_pkg::S_RESP;
               end else begin
                  state_in = bpa_pkg::S_CARVE;
               end
            end
         end
         bpa_pkg::S_CARVE: begin
            state_in = (left_ff == '0) ? bpa_pkg::S_RESP : bpa_pkg::S_PUSH_HEAD;
         end
         bpa_pkg::S_PUSH_HEAD: begin
            if (head_ff[push_ord_ff] < NIL) begin
               state_in = bpa_pkg::S_PUSH_LINK;
            end else if (after_init) begin
               state_in = bpa_pkg::S_CARVE;
            end else if (after_alloc) begin
               state_in = bpa_pkg::S_SPLIT;
            end else begin
               state_in = bpa_pkg::S_RESP;
            end
         end
         bpa_pkg::S_PUSH_LINK: begin
            if (after_init) begin
               state_in = bpa_pkg::S_CARVE;
            end else if (after_alloc) begin
               state_in = bpa_pkg::S_SPLIT;
            end else begin
               state_in = bpa_pkg::S_RESP;
            end
         end
         bpa_pkg::S_ALLOC_READ:   state_in = bpa_pkg::S_ALLOC_UNLINK;
         bpa_pkg::S_ALLOC_UNLINK: state_in = bpa_pkg::S_SPLIT;
         bpa_pkg::S_SPLIT: begin
            state_in = (i_ff > ord_ff) ? bpa_pkg::S_PUSH_HEAD : bpa_pkg::S_RESP;
         end
         bpa_pkg::S_FREE_READ:    state_in = bpa_pkg::S_FREE_CHECK;
         bpa_pkg::S_FREE_CHECK: begin
            state_in = tag_match ? bpa_pkg::S_MERGE_READ : bpa_pkg::S_RESP;
         end
         bpa_pkg::S_MERGE_READ: begin
            state_in = merge_ok ? bpa_pkg::S_MERGE_TEST : bpa_pkg::S_PUSH_HEAD;
         end
         bpa_pkg::S_MERGE_TEST: begin
            state_in = buddy_free ? bpa_pkg::S_MERGE_READ : bpa_pkg::S_PUSH_HEAD;
         end
         bpa_pkg::S_RESP: begin
            if (slot_free) begin
               state_in = bpa_pkg::S_IDLE;
            end
         end
         default: state_in = bpa_pkg::S_IDLE;
      endcase
   end

   // Datapath, memory controls and handshake outputs
   always_comb begin
      op_in         = op_ff;
      ord_in        = ord_ff;
      i_in          = i_ff;
      cur_in        = cur_ff;
      buddy_in      = buddy_ff;
      push_ord_in   = push_ord_ff;
      push_page_in  = push_page_ff;
      old_head_in   = old_head_ff;
      carve_page_in = carve_page_ff;
      left_in       = left_ff;
      clear_addr_in = clear_addr_ff;
      boot_in       = boot_ff;
      head_in       = head_ff;
      rst_in        = rst_ff;
      rord_in       = rord_ff;
      rpg_in        = rpg_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      rd_addr       = cur_ff;
      we            = '0;
      tag_wa        = cur_ff;
      tag_wd        = '0;
      next_wa       = push_page_ff;
      next_wd       = head_ff[push_ord_ff];
      prev_wa       = push_page_ff;
      prev_wd       = NIL;
      case (state_ff)
         bpa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in   = req_op;
               ord_in  = req_ord;
               rst_in  = bpa_pkg::STAT_OK;
               rord_in = '0;
               rpg_in  = '0;
               case (req_op)
                  bpa_pkg::OP_ALLOC: begin
                     if (count_bad) begin
                        rst_in = bpa_pkg::STAT_BAD_CNT;
                     end else begin
                        rord_in = bpa_pkg::ORD_OUT_W'(req_ord);
                        i_in    = found_ord;
                        cur_in  = head_ff[found_ord][PW-1:0];
                        if (!found) begin
                           rst_in = bpa_pkg::STAT_NO_FREE;
                        end
                     end
                  end
                  bpa_pkg::OP_FREE: begin
                     if (count_bad) begin
                        rst_in = bpa_pkg::STAT_BAD_CNT;
                     end else begin
                        rord_in = bpa_pkg::ORD_OUT_W'(req_ord);
                        cur_in  = PW'(req_page);
                        if (free_bad) begin
                           rst_in = bpa_pkg::STAT_BAD_PAGE;
                        end else begin
                           rpg_in = req_page;
                        end
                     end
                  end
                  bpa_pkg::OP_INIT: begin
                     clear_addr_in = '0;
                     for (int k = 0; k < ORDER_COUNT; k++) begin
                        head_in[k] = NIL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bpa_pkg::S_CLEAR: begin
            // Sweep every tag back to used, order zero
            we.tag_we     = 1'b1;
            tag_wa        = clear_addr_ff;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == LAST_PAGE) begin
               boot_in       = 1'b0;
               carve_page_in = res_ext;
               left_in       = pool_eff - res_ext;
            end
         end
         bpa_pkg::S_CARVE: begin
            push_ord_in   = carve_ord;
            push_page_in  = carve_page_ff[PW-1:0];
            carve_page_in = carve_page_ff + (AW'(1) << carve_ord);
            left_in       = left_ff - (AW'(1) << carve_ord);
         end
         bpa_pkg::S_PUSH_HEAD: begin
            // Link the block in front of the old head
            we.tag_we  = 1'b1;
            we.next_we = 1'b1;
            we.prev_we = 1'b1;
            tag_wa     = push_page_ff;
            tag_wd     = {1'b1, push_ord_ff};
            old_head_in = head_ff[push_ord_ff];
            head_in[push_ord_ff] = LW'(push_page_ff);
         end
         bpa_pkg::S_PUSH_LINK: begin
            we.prev_we = old_valid;
            prev_wa    = old_head_ff[PW-1:0];
            prev_wd    = LW'(push_page_ff);
         end
         bpa_pkg::S_ALLOC_READ: begin
            rd_addr = cur_ff;
         end
         bpa_pkg::S_ALLOC_UNLINK: begin
            // Drop the head block from its list and mark it allocated
            head_in[i_ff] = next_rd;
            we.prev_we    = head_valid;
            prev_wa       = next_rd[PW-1:0];
            prev_wd       = NIL;
            we.tag_we     = 1'b1;
            tag_wa        = cur_ff;
            tag_wd        = {1'b0, ord_ff};
         end
         bpa_pkg::S_SPLIT: begin
            if (i_ff > ord_ff) begin
               push_ord_in  = i_ff - 1'b1;
               push_page_in = PW'(cur_ext + (AW'(1) << (i_ff - 1'b1)));
               i_in         = i_ff - 1'b1;
            end else begin
               rpg_in = bpa_pkg::PAGE_W'(cur_ff);
            end
         end
         bpa_pkg::S_FREE_READ: begin
            rd_addr = cur_ff;
         end
         bpa_pkg::S_FREE_CHECK: begin
            if (tag_match) begin
               we.tag_we = 1'b1;
               tag_wa    = cur_ff;
               tag_wd    = '0;
               i_in      = ord_ff;
            end else begin
               rst_in = bpa_pkg::STAT_BAD_PAGE;
               rpg_in = '0;
            end
         end
         bpa_pkg::S_MERGE_READ: begin
            buddy_in = PW'(buddy_a);
            rd_addr  = PW'(buddy_a);
            if (!merge_ok) begin
               push_ord_in  = i_ff;
               push_page_in = cur_ff;
            end
         end
         bpa_pkg::S_MERGE_TEST: begin
            if (buddy_free) begin
               // Unlink the buddy and fold the pair into one block
               if (prev_rd < NIL) begin
                  we.next_we = 1'b1;
                  next_wa    = prev_rd[PW-1:0];
                  next_wd    = next_rd;
               end else begin
                  head_in[i_ff] = next_rd;
               end
               we.prev_we = head_valid;
               prev_wa    = next_rd[PW-1:0];
               prev_wd    = prev_rd;
               we.tag_we  = 1'b1;
               tag_wd     = '0;
               if (buddy_ff < cur_ff) begin
                  tag_wa = cur_ff;
                  cur_in = buddy_ff;
               end else begin
                  tag_wa = buddy_ff;
               end
               i_in = i_ff + 1'b1;
            end else begin
               push_ord_in  = i_ff;
               push_page_in = cur_ff;
            end
         end
         bpa_pkg::S_RESP: begin
            res_valid = slot_free;
         end
         default: begin
         end
      endcase
   end

   assign res_data.status = rst_ff;
   assign res_data.order  = rord_ff;
   assign res_data.page   = rpg_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bpa_pkg::S_CLEAR;
         boot_ff       <= 1'b1;
         clear_addr_ff <= '0;
         for (int k = 0; k < ORDER_COUNT; k++) begin
            head_ff[k] <= NIL;
         end
      end else begin
         state_ff      <= state_in;
         boot_ff       <= boot_in;
         clear_addr_ff <= clear_addr_in;
         head_ff       <= head_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      ord_ff        <= ord_in;
      i_ff          <= i_in;
      cur_ff        <= cur_in;
      buddy_ff      <= buddy_in;
      push_ord_ff   <= push_ord_in;
      push_page_ff  <= push_page_in;
      old_head_ff   <= old_head_in;
      carve_page_ff <= carve_page_in;
      left_ff       <= left_in;
      rst_ff        <= rst_in;
      rord_ff       <= rord_in;
      rpg_ff        <= rpg_in;
   end

   `BPA_ASSERT_NOW(a_split_order, clock, reset, state_ff == bpa_pkg::S_SPLIT, i_ff >= ord_ff)
   `BPA_ASSERT_NOW(a_merge_range, clock, reset, state_ff == bpa_pkg::S_MERGE_TEST, (32'(i_ff) + 1) < ORDER_COUNT)
   `BPA_ASSERT_NEXT(a_clear_end, clock, reset, state_ff == bpa_pkg::S_CLEAR && clear_addr_ff == LAST_PAGE, state_ff != bpa_pkg::S_CLEAR)
   `BPA_ASSERT_NOW(a_alloc_head, clock, reset, state_ff == bpa_pkg::S_ALLOC_READ, head_ff[i_ff] == LW'(cur_ff))

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the buddy page allocator: directed and random request streams.

class alloc_scoreboard;
   int unsigned pool_reg;
   int unsigned res_reg;
   int unsigned head[11];
   int unsigned nxt[4096];
   int unsigned prv[4096];
   bit [4:0]    tag[4096];
   bit [23:0]   pending[$];
   int          errors;
   int          checked;
   int          n_ok;
   int          n_nofree;
   int          n_badcnt;
   int          n_badpage;
   int unsigned held[$];   // pages of blocks handed out, with order in bits 15:12

   function new();
      pool_reg = 4096;
      res_reg = 0;
      foreach (head[i]) head[i] = 4096;
      foreach (tag[i]) tag[i] = 0;
   endfunction

   function int unsigned eff_pool();
      return (pool_reg > 4096) ? 4096 : pool_reg;
   endfunction

   function int unsigned flog2(int unsigned v);
      int unsigned r;
      r = 0;
      while (v > 1) begin
         v >>= 1;
         r++;
      end
      return r;
   endfunction

   function void push_blk(int unsigned o, int unsigned p);
      int unsigned h;
      h = head[o];
      prv[p] = 4096;
      nxt[p] = h;
      if (h < 4096) prv[h] = p;
      head[o] = p;
      tag[p] = 5'(16 | o);
   endfunction

   function void unlink_blk(int unsigned o, int unsigned p);
      int unsigned pv;
      int unsigned nx;
      pv = prv[p];
      nx = nxt[p];
      if (pv < 4096) nxt[pv] = nx;
      else head[o] = nx;
      if (nx < 4096) prv[nx] = pv;
   endfunction

   // Work out the result of one accepted request and queue it
   function void note_request(bit [1:0] op, int unsigned cnt, int unsigned page);
      int unsigned pool;
      int unsigned pg;
      int unsigned ord;
      int unsigned j;
      int unsigned p;
      int unsigned sz;
      int unsigned cur;
      int unsigned i;
      int unsigned buddy;
      int unsigned left;
      bit [1:0]    st;
      pool = eff_pool();
      pg = 0;
      ord = 0;
      st = bpa_pkg::STAT_OK;
      if (op == bpa_pkg::OP_INIT) begin
         foreach (head[k]) head[k] = 4096;
         foreach (tag[k]) tag[k] = 0;
         held.delete();
         if (res_reg < pool) begin
            i = res_reg;
            left = pool - res_reg;
            while (left != 0) begin
               j = flog2(left);
               if (j > 10) j = 10;
               push_blk(j, i);
               i += 1 << j;
               left -= 1 << j;
            end
         end
      end else if (op == bpa_pkg::OP_ALLOC || op == bpa_pkg::OP_FREE) begin
         if (cnt == 0 || cnt > 1024) begin
            st = bpa_pkg::STAT_BAD_CNT;
         end else begin
            ord = flog2(cnt);
            if ((cnt & (cnt - 1)) != 0) ord++;
            if (op == bpa_pkg::OP_ALLOC) begin
               j = ord;
               while (j < 11 && head[j] >= 4096) j++;
               if (j >= 11) begin
                  st = bpa_pkg::STAT_NO_FREE;
               end else begin
                  p = head[j];
                  unlink_blk(j, p);
                  tag[p] = 5'(ord);
                  for (i = j; i > ord; i--) push_blk(i - 1, p + (1 << (i - 1)));
                  pg = p;
                  held.push_back(p | (ord << 12));
               end
            end else begin
               sz = 1 << ord;
               if (page < res_reg || page + sz > pool || ((page - res_reg) & (sz - 1)) != 0
                   || tag[page] != 5'(ord)) begin
                  st = bpa_pkg::STAT_BAD_PAGE;
               end else begin
                  tag[page] = 0;
                  cur = page;
                  i = ord;
                  while (i + 1 < 11) begin
                     sz = 1 << i;
                     buddy = (((cur - res_reg) & sz) != 0) ? cur - sz : cur + sz;
                     if (buddy + sz > pool) break;
                     if (tag[buddy] != 5'(16 | i)) break;
                     unlink_blk(i, buddy);
                     if (buddy < cur) begin
                        tag[cur] = 0;
                        cur = buddy;
                     end else begin
                        tag[buddy] = 0;
                     end
                     i++;
                  end
                  push_blk(i, cur);
                  pg = page;
               end
            end
         end
      end
      case (st)
         bpa_pkg::STAT_OK:       n_ok++;
         bpa_pkg::STAT_NO_FREE:  n_nofree++;
         bpa_pkg::STAT_BAD_CNT:  n_badcnt++;
         default:                n_badpage++;
      endcase
      pending.push_back({6'd0, st, 4'(ord), 12'(pg)});
   endfunction

   // Compare one result transfer with the oldest expectation
   function void check_result(bit [23:0] got);
      bit [23:0] exp_w;
      if (pending.size() == 0) begin
         $error("unexpected result 0x%06h", got);
         errors++;
         return;
      end
      exp_w = pending.pop_front();
      checked++;
      if (got[11:0] != exp_w[11:0]) begin
         $error("page_index_out: expected %0d, got %0d", exp_w[11:0], got[11:0]);
         errors++;
      end
      if (got[15:12] != exp_w[15:12]) begin
         $error("granted_order: expected %0d, got %0d", exp_w[15:12], got[15:12]);
         errors++;
      end
      if (got[17:16] != exp_w[17:16]) begin
         $error("status: expected %0d, got %0d", exp_w[17:16], got[17:16]);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [12:0] csr_wdata;

   alloc_scoreboard sb;
   int unsigned     cycles;

   localparam int unsigned CYCLE_LIMIT = 3000000;
   // Operation code with no meaning to the block
   localparam logic [bpa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   buddy_page_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
      return 0;
   endfunction

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Check result transfers and stall the receiver at random
   int unsigned stall_left;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if ((rsp_tvalid && rsp_tready) || !rsp_tready) begin
            stall_left <= gap_len();
            rsp_tready <= 1'b1;
         end
      end
   end

   // Valid stays high after a transfer unless a gap follows
   task automatic send_req(bit [1:0] op, int unsigned cnt, int unsigned page);
      int unsigned g;
      g = gap_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, 12'(page), 12'(cnt), op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, cnt, page);
   endtask

   // Wait until every result has arrived, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(bit idx, int unsigned val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 13'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == bpa_pkg::CSR_POOL) sb.pool_reg = val & 13'h1FFF;
      else sb.res_reg = val & 12'hFFF;
   endtask

   // Mostly well-formed alloc/free with random sizes, some noise
   task automatic random_phase(int n);
      int unsigned k;
      int unsigned e;
      int unsigned c;
      for (int t = 0; t < n; t++) begin
         k = $urandom_range(0, 99);
         c = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024)
                                         : $urandom_range(1, 1 << $urandom_range(0, 6));
         if (k < 45) begin
            send_req(bpa_pkg::OP_ALLOC, c, $urandom_range(0, 4095));
         end else if (k < 85 && sb.held.size() != 0) begin
            e = $urandom_range(0, sb.held.size() - 1);
            c = 1 << (sb.held[e] >> 12);
            if (c > 1 && $urandom_range(0, 1)) c = $urandom_range(c / 2 + 1, c);
            send_req(bpa_pkg::OP_FREE, c, sb.held[e] & 12'hFFF);
            sb.held.delete(e);
         end else if (k < 93) begin
            send_req(bpa_pkg::OP_FREE, $urandom_range(0, 4095), $urandom_range(0, 4095));
         end else if (k < 97) begin
            send_req(bpa_pkg::OP_ALLOC, $urandom_range(0, 1) ? 0 : $urandom_range(1025, 4095),
                     0);
         end else if (k < 99) begin
            send_req(OP_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 4095));
         end else begin
            send_req(bpa_pkg::OP_INIT, $urandom_range(0, 4095), $urandom_range(0, 4095));
         end
      end
   endtask

   // Directed part, then random phases over several register settings
   initial begin
      sb = new();
      cycles = 0;
      stall_left = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = bpa_pkg::CSR_POOL;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Allocate before any init finds no block
      send_req(bpa_pkg::OP_ALLOC, 1, 0);
      send_req(bpa_pkg::OP_INIT, 0, 0);
      send_req(bpa_pkg::OP_ALLOC, 0, 0);
      send_req(bpa_pkg::OP_ALLOC, 1025, 0);
      send_req(bpa_pkg::OP_ALLOC, 4095, 4095);
      send_req(bpa_pkg::OP_ALLOC, 1024, 0);
      send_req(bpa_pkg::OP_ALLOC, 1, 0);
      send_req(bpa_pkg::OP_ALLOC, 3, 0);
      send_req(bpa_pkg::OP_FREE, 2, 1025);
      send_req(bpa_pkg::OP_FREE, 1, 1025);
      send_req(bpa_pkg::OP_FREE, 1, 4095);
      send_req(bpa_pkg::OP_FREE, 4, 1028);
      send_req(bpa_pkg::OP_FREE, 1, 1024);
      send_req(bpa_pkg::OP_FREE, 1024, 0);
      send_req(OP_UNUSED, 4095, 4095);
      send_req(bpa_pkg::OP_FREE, 0, 0);
      for (int t = 0; t < 5; t++) send_req(bpa_pkg::OP_ALLOC, 1024, 0);
      send_req(bpa_pkg::OP_FREE, 1024, 3072);
      drain();

      // Register settings, extremes included
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_csr(bpa_pkg::CSR_POOL, 1);
               write_csr(bpa_pkg::CSR_RESERVED, 0);
            end
            1: begin
               write_csr(bpa_pkg::CSR_POOL, 8191);
               write_csr(bpa_pkg::CSR_RESERVED, 4095);
            end
            2: begin
               write_csr(bpa_pkg::CSR_POOL, 4096);
               write_csr(bpa_pkg::CSR_RESERVED, 3);
            end
            3: begin
               write_csr(bpa_pkg::CSR_POOL, 300);
               write_csr(bpa_pkg::CSR_RESERVED, 17);
            end
            default: begin
               write_csr(bpa_pkg::CSR_POOL, $urandom_range(1, 8191));
               write_csr(bpa_pkg::CSR_RESERVED, $urandom_range(0, 4095));
            end
         endcase
         send_req(bpa_pkg::OP_INIT, 0, 0);
         random_phase(200);
         drain();
      end

      $display("checked %0d results over 8 register settings", sb.checked);
      $display("ok %0d, no block %0d, bad count %0d, bad page %0d",
               sb.n_ok, sb.n_nofree, sb.n_badcnt, sb.n_badpage);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
